>>> rtl/tvbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the trellis Viterbi block decoder.
// No dependencies.
package tvbd_pkg;

  localparam int MAX_STATES      = 64;
  localparam int MAX_PREDS       = 4;
  localparam int MAX_BLOCK       = 64;
  localparam int MAX_OUT_SYMBOLS = 16;
  localparam int METRIC_BITS     = 16;
  localparam int PM_BITS         = 24;

  localparam int STATE_W = 6;
  localparam int SLOT_W  = 2;
  localparam int ENTRY_W = STATE_W + SLOT_W;

  typedef logic [PM_BITS-1:0]     pm_t;
  typedef logic [METRIC_BITS-1:0] metric_t;

  localparam pm_t PM_INF = '1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_METRIC = 1'b1;

  localparam logic [2:0] REG_NUM_STATES  = 3'd0;
  localparam logic [2:0] REG_NUM_OUT_SYM = 3'd1;
  localparam logic [2:0] REG_BLOCK_LEN   = 3'd2;
  localparam logic [2:0] REG_START_STATE = 3'd3;
  localparam logic [2:0] REG_END_STATE   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACS,
    ST_FIND,
    ST_WALK,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic [STATE_W-1:0] prev;
    logic [7:0]         insym;
    logic [3:0]         outsym;
  } pred_entry_t;

  typedef struct packed {
    logic              vld;
    logic              usable;
    logic              first;
    logic              last_slot;
    logic [SLOT_W-1:0] slot;
    pm_t               pm;
    metric_t           metric;
  } acs_in_t;

  typedef struct packed {
    logic              wr;
    pm_t               best;
    logic [SLOT_W-1:0] slot;
    pm_t               norm;
  } acs_out_t;

  function automatic logic [6:0] clamp_ns(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MAX_STATES)) return 7'(MAX_STATES);
    return v;
  endfunction

  function automatic logic [4:0] clamp_no(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_OUT_SYMBOLS)) return 5'(MAX_OUT_SYMBOLS);
    return v;
  endfunction

  function automatic logic [6:0] clamp_len(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MAX_BLOCK)) return 7'(MAX_BLOCK);
    return v;
  endfunction

endpackage

>>> rtl/tvbd_acs_unit.sv
`timescale 1ns / 1ps
// Add-compare-select accumulator: saturating add, first strict minimum per state,
// running step minimum. Depends on tvbd_pkg.
module tvbd_acs_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               norm_clr,
  input  tvbd_pkg::acs_in_t  acs_i,
  output tvbd_pkg::acs_out_t acs_o
);

  tvbd_pkg::pm_t                   best_r;
  logic [tvbd_pkg::SLOT_W-1:0]     slot_r;
  tvbd_pkg::pm_t                   norm_r;
  logic [tvbd_pkg::PM_BITS:0]      wide_sum;
  tvbd_pkg::pm_t                   sum;
  tvbd_pkg::pm_t                   base_best;
  logic [tvbd_pkg::SLOT_W-1:0]     base_slot;
  tvbd_pkg::pm_t                   new_best;
  logic [tvbd_pkg::SLOT_W-1:0]     new_slot;
  logic                            win;

  always_comb begin
    wide_sum = {1'b0, acs_i.pm} + (tvbd_pkg::PM_BITS + 1)'(acs_i.metric);
    if (acs_i.pm == tvbd_pkg::PM_INF || wide_sum > {1'b0, tvbd_pkg::PM_INF}) begin
      sum = tvbd_pkg::PM_INF;
    end else begin
      sum = wide_sum[tvbd_pkg::PM_BITS-1:0];
    end
    base_best = acs_i.first ? tvbd_pkg::PM_INF : best_r;
    base_slot = acs_i.first ? '0 : slot_r;
    win       = acs_i.usable && (sum < base_best);
    new_best  = win ? sum : base_best;
    new_slot  = win ? acs_i.slot : base_slot;
    acs_o.wr   = acs_i.vld && acs_i.last_slot;
    acs_o.best = new_best;
    acs_o.slot = new_slot;
    acs_o.norm = (acs_o.wr && new_best < norm_r) ? new_best : norm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= tvbd_pkg::PM_INF;
    end else if (norm_clr) begin
      norm_r <= tvbd_pkg::PM_INF;
    end else begin
      norm_r <= acs_o.norm;
    end
  end

  always_ff @(posedge clk) begin
    if (acs_i.vld) begin
      best_r <= new_best;
      slot_r <= new_slot;
    end
  end

endmodule

>>> rtl/trellis_viterbi_block_decoder.sv
`timescale 1ns / 1ps
// Top level of the trellis Viterbi block decoder: control, memories, traceback.
// Depends on tvbd_pkg and tvbd_acs_unit.
//
// Usage: load the predecessor table (operation 0), then feed branch metrics
// (operation 1), num_out_symbols per trellis step. A load or a metric that does
// not close a step is taken in idle and busy stays low. The metric that closes a
// step starts add-compare-select, which walks the (state, slot) entries of the
// predecessor table for every state in use through the path-metric memory; busy
// is high while it runs. The metric that closes a block adds traceback: a
// best-state scan over the path-metric memory (skipped when end_state names a
// state in range), a walk of the survivor and predecessor memories for each
// step, then an emit pass that puts the decoded symbols out in block order, one
// per cycle on out_valid, last marked by out_last. The receiver cannot stall:
// each result beat is present for exactly one cycle. Configuration writes are
// always accepted (cfg_ready is tied high) and take effect at once.
module trellis_viterbi_block_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [5:0] in_target_state,
  input  logic [1:0] in_slot,
  input  logic [5:0] in_prev_state,
  input  logic [7:0] in_input_symbol,
  input  logic [3:0] in_output_symbol,
  input  logic [15:0] in_metric,
  input  logic       in_packet_start,
  output logic       out_valid,
  output logic [7:0] out_decoded_symbol,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int PRED_DEPTH = tvbd_pkg::MAX_STATES * tvbd_pkg::MAX_PREDS;
  localparam int SW         = tvbd_pkg::STATE_W;

  // configuration
  logic [6:0] cfg_ns_r, cfg_len_r, cfg_start_r, cfg_end_r;
  logic [4:0] cfg_no_r;
  logic [6:0] ns;
  logic [4:0] no;
  logic [6:0] len;
  logic [8:0] ns4;

  // memories
  tvbd_pkg::pred_entry_t pred_mem [PRED_DEPTH];
  tvbd_pkg::pm_t         pm_mem   [2*tvbd_pkg::MAX_STATES];
  logic [tvbd_pkg::SLOT_W-1:0] surv_mem [tvbd_pkg::MAX_BLOCK*tvbd_pkg::MAX_STATES];
  logic [7:0]            obuf_mem [tvbd_pkg::MAX_BLOCK];
  logic [PRED_DEPTH-1:0] pred_valid_r;
  tvbd_pkg::metric_t     mbuf_r [tvbd_pkg::MAX_OUT_SYMBOLS];

  tvbd_pkg::pred_entry_t       pred_q;
  tvbd_pkg::pm_t               pm_q;
  logic [tvbd_pkg::SLOT_W-1:0] surv_q;
  logic [7:0]                  obuf_q;

  logic [tvbd_pkg::ENTRY_W-1:0] pred_raddr;
  logic [SW:0]                  pm_raddr;
  logic [11:0]                  surv_raddr;
  logic [5:0]                   obuf_raddr;
  logic                         pred_we, mbuf_we, obuf_we;
  logic [3:0]                   mbuf_waddr;

  // control
  tvbd_pkg::fsm_t state_r, state_nxt;
  logic [6:0] step_r, step_nxt;
  logic [3:0] sym_r, sym_nxt;
  logic       bank_r, bank_nxt;
  logic       init_r, init_nxt;
  logic       init_known_r, init_known_nxt;
  logic [5:0] init_s0_r, init_s0_nxt;
  logic [6:0] len_r, len_nxt;
  tvbd_pkg::pm_t norm_bank_r [2];
  logic       norm_clr;

  // ACS pipeline
  logic [8:0] acs_cnt_r, acs_cnt_nxt;
  logic       a_vld_r, a_vld_nxt;
  logic [7:0] a_e_r, a_e_nxt;
  logic       b_vld_r, b_use_r;
  logic [7:0] b_e_r;
  logic [5:0] b_ps_r;
  tvbd_pkg::metric_t b_m_r;
  logic       c_vld_r, c_use_r;
  logic [7:0] c_e_r;
  tvbd_pkg::pm_t c_pm_r;
  tvbd_pkg::metric_t c_m_r;
  logic       b_use;
  tvbd_pkg::pm_t pmn;
  tvbd_pkg::acs_in_t  acs_i;
  tvbd_pkg::acs_out_t acs_o;
  logic       step_done;

  // traceback
  logic [6:0] find_cnt_r, find_cnt_nxt;
  logic       f_vld_r, f_vld_nxt;
  logic [5:0] f_j_r, f_j_nxt;
  tvbd_pkg::pm_t fbest_r, fbest_nxt;
  logic [5:0] st_r, st_nxt;
  logic [6:0] k_r, k_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [7:0] w_e_r, w_e_nxt;
  logic [7:0] w_sym;
  logic [6:0] em_cnt_r, em_cnt_nxt;
  logic       em_vld_r, em_vld_nxt;
  logic       em_last_r, em_last_nxt;
  logic       start_known, end_known;

  assign ns  = tvbd_pkg::clamp_ns(cfg_ns_r);
  assign no  = tvbd_pkg::clamp_no(cfg_no_r);
  assign len = tvbd_pkg::clamp_len(cfg_len_r);
  assign ns4 = {ns, 2'b00};
  assign start_known = !cfg_start_r[6] && (cfg_start_r < ns);
  assign end_known   = !cfg_end_r[6] && (cfg_end_r < ns);

  assign busy      = (state_r != tvbd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid          = em_vld_r;
  assign out_decoded_symbol = obuf_q;
  assign out_last           = em_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ns_r    <= 7'd4;
      cfg_no_r    <= 5'd4;
      cfg_len_r   <= 7'd64;
      cfg_start_r <= 7'h7f;
      cfg_end_r   <= 7'h7f;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvbd_pkg::REG_NUM_STATES:  cfg_ns_r    <= cfg_data;
        tvbd_pkg::REG_NUM_OUT_SYM: cfg_no_r    <= cfg_data[4:0];
        tvbd_pkg::REG_BLOCK_LEN:   cfg_len_r   <= cfg_data;
        tvbd_pkg::REG_START_STATE: cfg_start_r <= cfg_data;
        tvbd_pkg::REG_END_STATE:   cfg_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ACS stage B: predecessor entry is back, fetch its path metric
  assign b_use = pred_valid_r[a_e_r] && ({1'b0, pred_q.prev} < ns)
               && ({1'b0, pred_q.outsym} < no);

  // ACS stage C: normalize the fetched metric (first step reads the start values)
  always_comb begin
    if (init_r) begin
      pmn = (!init_known_r || b_ps_r == init_s0_r) ? '0 : tvbd_pkg::PM_INF;
    end else if (pm_q == tvbd_pkg::PM_INF) begin
      pmn = tvbd_pkg::PM_INF;
    end else begin
      pmn = pm_q - norm_bank_r[bank_r];
    end
  end

  always_comb begin
    acs_i.vld       = c_vld_r;
    acs_i.usable    = c_use_r;
    acs_i.first     = (c_e_r[1:0] == '0);
    acs_i.last_slot = (c_e_r[1:0] == tvbd_pkg::SLOT_W'(tvbd_pkg::MAX_PREDS - 1));
    acs_i.slot      = c_e_r[1:0];
    acs_i.pm        = c_pm_r;
    acs_i.metric    = c_m_r;
  end

  tvbd_acs_unit u_acs (
    .clk      (clk),
    .rst_n    (rst_n),
    .norm_clr (norm_clr),
    .acs_i    (acs_i),
    .acs_o    (acs_o)
  );

  assign step_done = acs_o.wr && ({1'b0, c_e_r} == ns4 - 9'd1);

  // traceback symbol: unusable entries decode to 0 and continue from state 0
  always_comb begin
    if (pred_valid_r[w_e_r] && ({1'b0, pred_q.prev} < ns)) begin
      w_sym = pred_q.insym;
    end else begin
      w_sym = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    sym_nxt        = sym_r;
    bank_nxt       = bank_r;
    init_nxt       = init_r;
    init_known_nxt = init_known_r;
    init_s0_nxt    = init_s0_r;
    len_nxt        = len_r;
    acs_cnt_nxt    = acs_cnt_r;
    a_vld_nxt      = 1'b0;
    a_e_nxt        = a_e_r;
    find_cnt_nxt   = find_cnt_r;
    f_vld_nxt      = 1'b0;
    f_j_nxt        = f_j_r;
    fbest_nxt      = fbest_r;
    st_nxt         = st_r;
    k_nxt          = k_r;
    ph_nxt         = ph_r;
    w_e_nxt        = w_e_r;
    em_cnt_nxt     = em_cnt_r;
    em_vld_nxt     = 1'b0;
    em_last_nxt    = em_last_r;
    pred_we        = 1'b0;
    mbuf_we        = 1'b0;
    mbuf_waddr     = sym_r;
    obuf_we        = 1'b0;
    norm_clr       = 1'b0;
    pred_raddr     = acs_cnt_r[7:0];
    pm_raddr       = {bank_r, pred_q.prev};
    surv_raddr     = {k_r[5:0], st_r};
    obuf_raddr     = em_cnt_r[5:0];

    case (state_r)
      tvbd_pkg::ST_IDLE: begin
        if (start) begin
          if (in_operation == tvbd_pkg::OP_LOAD) begin
            pred_we = 1'b1;
          end else begin
            // packet start mid-block drops the partial block
            if (in_packet_start) begin
              step_nxt = '0;
              sym_nxt  = '0;
            end
            if ((in_packet_start) || (step_r == '0 && sym_r == '0)) begin
              init_nxt       = 1'b1;
              bank_nxt       = 1'b0;
              init_known_nxt = start_known;
              init_s0_nxt    = cfg_start_r[5:0];
            end
            mbuf_we    = 1'b1;
            mbuf_waddr = sym_nxt;
            if (({1'b0, sym_nxt} + 5'd1) < no) begin
              sym_nxt = sym_nxt + 4'd1;
            end else begin
              sym_nxt     = '0;
              len_nxt     = len;
              acs_cnt_nxt = '0;
              norm_clr    = 1'b1;
              state_nxt   = tvbd_pkg::ST_ACS;
            end
          end
        end
      end

      tvbd_pkg::ST_ACS: begin
        if (acs_cnt_r < ns4) begin
          pred_raddr  = acs_cnt_r[7:0];
          a_vld_nxt   = 1'b1;
          a_e_nxt     = acs_cnt_r[7:0];
          acs_cnt_nxt = acs_cnt_r + 9'd1;
        end
        if (step_done) begin
          bank_nxt = ~bank_r;
          init_nxt = 1'b0;
          if ((step_r + 7'd1) < len_r) begin
            step_nxt  = step_r + 7'd1;
            state_nxt = tvbd_pkg::ST_IDLE;
          end else begin
            step_nxt     = '0;
            find_cnt_nxt = '0;
            fbest_nxt    = tvbd_pkg::PM_INF;
            st_nxt       = '0;
            state_nxt    = tvbd_pkg::ST_FIND;
          end
        end
      end

      tvbd_pkg::ST_FIND: begin
        k_nxt  = len_r - 7'd1;
        ph_nxt = '0;
        if (end_known) begin
          st_nxt    = cfg_end_r[5:0];
          state_nxt = tvbd_pkg::ST_WALK;
        end else begin
          pm_raddr = {bank_r, find_cnt_r[5:0]};
          if (find_cnt_r < ns) begin
            f_vld_nxt    = 1'b1;
            f_j_nxt      = find_cnt_r[5:0];
            find_cnt_nxt = find_cnt_r + 7'd1;
          end
          if (f_vld_r) begin
            if (pm_q < fbest_r) begin
              fbest_nxt = pm_q;
              st_nxt    = f_j_r;
            end
            if ({1'b0, f_j_r} == ns - 7'd1) begin
              state_nxt = tvbd_pkg::ST_WALK;
            end
          end
        end
      end

      tvbd_pkg::ST_WALK: begin
        pred_raddr = {st_r, surv_q};
        case (ph_r)
          2'd0: begin
            ph_nxt = 2'd1;
          end
          2'd1: begin
            w_e_nxt = {st_r, surv_q};
            ph_nxt  = 2'd2;
          end
          default: begin
            obuf_we = 1'b1;
            st_nxt  = (w_sym == pred_q.insym && pred_valid_r[w_e_r]
                       && ({1'b0, pred_q.prev} < ns)) ? pred_q.prev : '0;
            ph_nxt  = 2'd0;
            if (k_r == '0) begin
              em_cnt_nxt = '0;
              state_nxt  = tvbd_pkg::ST_EMIT;
            end else begin
              k_nxt = k_r - 7'd1;
            end
          end
        endcase
      end

      tvbd_pkg::ST_EMIT: begin
        if (em_cnt_r < len_r) begin
          em_vld_nxt  = 1'b1;
          em_last_nxt = (em_cnt_r == len_r - 7'd1);
          em_cnt_nxt  = em_cnt_r + 7'd1;
        end
        if (em_vld_r && em_last_r) begin
          state_nxt = tvbd_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tvbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tvbd_pkg::ST_IDLE;
      step_r       <= '0;
      sym_r        <= '0;
      bank_r       <= 1'b0;
      init_r       <= 1'b0;
      pred_valid_r <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      f_vld_r      <= 1'b0;
      em_vld_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      sym_r    <= sym_nxt;
      bank_r   <= bank_nxt;
      init_r   <= init_nxt;
      a_vld_r  <= a_vld_nxt;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
      f_vld_r  <= f_vld_nxt;
      em_vld_r <= em_vld_nxt;
      if (pred_we) begin
        pred_valid_r[{in_target_state, in_slot}] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    init_known_r <= init_known_nxt;
    init_s0_r    <= init_s0_nxt;
    len_r        <= len_nxt;
    acs_cnt_r    <= acs_cnt_nxt;
    a_e_r        <= a_e_nxt;
    b_use_r      <= b_use;
    b_e_r        <= a_e_r;
    b_ps_r       <= pred_q.prev;
    b_m_r        <= mbuf_r[pred_q.outsym];
    c_use_r      <= b_use_r;
    c_e_r        <= b_e_r;
    c_pm_r       <= pmn;
    c_m_r        <= b_m_r;
    find_cnt_r   <= find_cnt_nxt;
    f_j_r        <= f_j_nxt;
    fbest_r      <= fbest_nxt;
    st_r         <= st_nxt;
    k_r          <= k_nxt;
    ph_r         <= ph_nxt;
    w_e_r        <= w_e_nxt;
    em_cnt_r     <= em_cnt_nxt;
    em_last_r    <= em_last_nxt;
    if (mbuf_we) begin
      mbuf_r[mbuf_waddr] <= in_metric;
    end
    if (step_done) begin
      norm_bank_r[~bank_r] <= acs_o.norm;
    end
  end

  // predecessor table
  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[{in_target_state, in_slot}] <= {in_prev_state, in_input_symbol,
                                               in_output_symbol};
    end
    pred_q <= pred_mem[pred_raddr];
  end

  // path metrics, two banks
  always_ff @(posedge clk) begin
    if (acs_o.wr) begin
      pm_mem[{~bank_r, c_e_r[7:2]}] <= acs_o.best;
    end
    pm_q <= pm_mem[pm_raddr];
  end

  // survivor slots, indexed by step and state
  always_ff @(posedge clk) begin
    if (acs_o.wr) begin
      surv_mem[{step_r[5:0], c_e_r[7:2]}] <= acs_o.slot;
    end
    surv_q <= surv_mem[surv_raddr];
  end

  // decoded symbols, written backward, read forward
  always_ff @(posedge clk) begin
    if (obuf_we) begin
      obuf_mem[k_r[5:0]] <= w_sym;
    end
    obuf_q <= obuf_mem[obuf_raddr];
  end

endmodule

>>> tb/sv/trellis_viterbi_block_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the trellis Viterbi block decoder.
// Depends on tvbd_pkg and the trellis_viterbi_block_decoder RTL.
module trellis_viterbi_block_decoder_test;
  import tvbd_pkg::*;

  // One input beat, every field at its port width.
  typedef struct {
    logic       op;
    logic [5:0] target;
    logic [1:0] slot;
    logic [5:0] prev;
    logic [7:0] insym;
    logic [3:0] outsym;
    logic [15:0] metric;
    logic       pkt;
  } beat_t;

  typedef struct {
    logic [7:0] sym;
    logic       last;
  } decoded_t;

  logic clk, rst_n;
  logic start, busy;
  logic in_operation, in_packet_start;
  logic [5:0] in_target_state, in_prev_state;
  logic [1:0] in_slot;
  logic [7:0] in_input_symbol;
  logic [3:0] in_output_symbol;
  logic [15:0] in_metric;
  logic out_valid, out_last;
  logic [7:0] out_decoded_symbol;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [6:0] cfg_data;

  beat_t    pending_beats[$];
  decoded_t decoded_q[$];
  int       n_queued, n_taken, errors, gap_left;
  bit       gaps_on;

  // Shadow copy of the decoder: predecessor table, path metrics, survivors.
  logic [5:0]  tr_prev[256];
  logic [7:0]  tr_insym[256];
  logic [3:0]  tr_outsym[256];
  bit          tr_vld[256];
  logic [23:0] pmet[2][64];
  logic [1:0]  surv[4096];
  logic [15:0] mbuf[16];
  int          step_cnt, sym_cnt;
  bit          bank;
  logic [6:0]  r_ns, r_len, r_start, r_end;
  logic [4:0]  r_no;

  trellis_viterbi_block_decoder i_dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_target_state, .in_slot, .in_prev_state,
    .in_input_symbol, .in_output_symbol, .in_metric, .in_packet_start,
    .out_valid, .out_decoded_symbol, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int clamp_cfg(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int eff_states();
    return clamp_cfg(r_ns, MAX_STATES);
  endfunction

  function automatic int eff_outs();
    return clamp_cfg(r_no, MAX_OUT_SYMBOLS);
  endfunction

  function automatic int eff_len();
    return clamp_cfg(r_len, MAX_BLOCK);
  endfunction

  // A 7-bit signed state register names a state only if non-negative and in range.
  function automatic bit names_state(logic [6:0] r);
    return !r[6] && (r < eff_states());
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Add-compare-select for one trellis step, then normalize by the step minimum.
  task automatic run_acs(input int k);
    int ns, no, e;
    bit cur;
    logic [23:0] best, norm, pm;
    logic [24:0] sum;
    logic [1:0] win;
    ns = eff_states();
    no = eff_outs();
    cur = bank;
    norm = PM_INF;
    for (int j = 0; j < ns; j++) begin
      best = PM_INF;
      win = '0;
      for (int s = 0; s < MAX_PREDS; s++) begin
        e = j * MAX_PREDS + s;
        if (!tr_vld[e] || tr_prev[e] >= ns || tr_outsym[e] >= no) continue;
        pm = pmet[cur][tr_prev[e]];
        if (pm == PM_INF) sum = PM_INF;
        else begin
          sum = pm + mbuf[tr_outsym[e]];
          if (sum > PM_INF) sum = PM_INF;
        end
        // strict compare: earlier slot keeps a tie
        if (sum < best) begin
          best = sum[23:0];
          win = s[1:0];
        end
      end
      surv[k * MAX_STATES + j] = win;
      pmet[!cur][j] = best;
      if (best < norm) norm = best;
    end
    for (int j = 0; j < ns; j++)
      if (pmet[!cur][j] != PM_INF) pmet[!cur][j] -= norm;
    bank = !cur;
  endtask

  // Walk the survivors back from the end or best state, queue symbols in block order.
  task automatic trace_block(input int len);
    int ns, st, e, nxt;
    logic [23:0] best;
    decoded_t blk[64];
    ns = eff_states();
    if (names_state(r_end)) st = r_end;
    else begin
      best = PM_INF;
      st = 0;
      for (int j = 0; j < ns; j++)
        if (pmet[bank][j] < best) begin
          best = pmet[bank][j];
          st = j;
        end
    end
    for (int k = len - 1; k >= 0; k--) begin
      e = st * MAX_PREDS + surv[k * MAX_STATES + st];
      blk[k].sym = 8'd0;
      nxt = 0;
      // unusable survivor entry: symbol 0, continue from state 0
      if (tr_vld[e] && tr_prev[e] < ns) begin
        blk[k].sym = tr_insym[e];
        nxt = tr_prev[e];
      end
      blk[k].last = (k == len - 1);
      st = nxt;
    end
    for (int k = 0; k < len; k++) decoded_q.push_back(blk[k]);
  endtask

  task automatic predict_beat(input beat_t b);
    int e;
    bit known;
    if (b.op == OP_LOAD) begin
      e = b.target * MAX_PREDS + b.slot;
      tr_prev[e] = b.prev;
      tr_insym[e] = b.insym;
      tr_outsym[e] = b.outsym;
      tr_vld[e] = 1'b1;
      return;
    end
    // packet start in mid-block drops the partial block
    if (b.pkt && (step_cnt != 0 || sym_cnt != 0)) begin
      step_cnt = 0;
      sym_cnt = 0;
    end
    if (step_cnt == 0 && sym_cnt == 0) begin
      known = names_state(r_start);
      for (int j = 0; j < 64; j++)
        pmet[0][j] = (!known || j == r_start) ? 24'd0 : PM_INF;
      bank = 1'b0;
    end
    mbuf[sym_cnt] = b.metric;
    sym_cnt++;
    if (sym_cnt < eff_outs()) return;
    sym_cnt = 0;
    run_acs(step_cnt);
    step_cnt++;
    if (step_cnt < eff_len()) return;
    step_cnt = 0;
    trace_block(eff_len());
  endtask

  // Driver: one beat per handshake, random gaps between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_beat('{in_operation, in_target_state, in_slot, in_prev_state,
                       in_input_symbol, in_output_symbol, in_metric, in_packet_start});
        n_taken++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        beat_t b;
        b = pending_beats.pop_front();
        in_operation <= b.op;
        in_target_state <= b.target;
        in_slot <= b.slot;
        in_prev_state <= b.prev;
        in_input_symbol <= b.insym;
        in_output_symbol <= b.outsym;
        in_metric <= b.metric;
        in_packet_start <= b.pkt;
        start <= 1'b1;
        if (!gaps_on || $urandom_range(0, 9) < 6) gap_left <= 0;
        else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(20, 60);
        else gap_left <= $urandom_range(1, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (decoded_q.size() == 0) report_mismatch("result beat with nothing expected");
      else begin
        decoded_t x;
        x = decoded_q.pop_front();
        if (out_decoded_symbol !== x.sym)
          report_mismatch($sformatf("symbol %0h, expected %0h", out_decoded_symbol, x.sym));
        if (out_last !== x.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, x.last));
      end
    end
  end

  task automatic push_beat(input beat_t b);
    pending_beats.push_back(b);
    n_queued++;
  endtask

  task automatic push_load(input int t, input int s, input int p, input int i, input int o);
    push_beat('{OP_LOAD, t[5:0], s[1:0], p[5:0], i[7:0], o[3:0], 16'($urandom), 1'b0});
  endtask

  task automatic push_metric(input int m, input bit pkt);
    push_beat('{OP_METRIC, 6'($urandom), 2'($urandom), 6'($urandom), 8'($urandom),
                4'($urandom), m[15:0], pkt});
  endtask

  // Idle point: all beats taken, all results seen, block back at rest.
  task automatic wait_drained();
    wait (pending_beats.size() == 0 && n_taken == n_queued && !start);
    wait (decoded_q.size() == 0);
    repeat (300) @(posedge clk);
    wait (!busy);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NUM_STATES:  r_ns = val;
      REG_NUM_OUT_SYM: r_no = val[4:0];
      REG_BLOCK_LEN:   r_len = val;
      REG_START_STATE: r_start = val;
      REG_END_STATE:   r_end = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Top up a block cut short by a packet start so the next phase starts clean.
  task automatic close_block();
    int need;
    wait_drained();
    if (step_cnt != 0 || sym_cnt != 0) begin
      need = (eff_len() - step_cnt) * eff_outs() - sym_cnt;
      repeat (need) push_metric($urandom_range(0, 255), 1'b0);
      wait_drained();
    end
  endtask

  function automatic int rand_metric();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return 65535;
      2: return 0;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Random trellis for the states in use, then whole blocks with a little noise.
  task automatic run_phase(input int ns, input int no, input int len, input int st,
                           input int en, input int blocks, input bit gaps);
    int ens, eno, elen;
    gaps_on = gaps;
    write_reg(REG_NUM_STATES, ns[6:0]);
    write_reg(REG_NUM_OUT_SYM, no[6:0]);
    write_reg(REG_BLOCK_LEN, len[6:0]);
    write_reg(REG_START_STATE, st[6:0]);
    write_reg(REG_END_STATE, en[6:0]);
    ens = eff_states();
    eno = eff_outs();
    elen = eff_len();
    for (int j = 0; j < ens; j++)
      for (int s = 0; s < MAX_PREDS; s++)
        if ($urandom_range(0, 3) != 0)
          push_load(j, s,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, ens - 1),
                    $urandom_range(0, 255),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, eno - 1));
    for (int b = 0; b < blocks; b++)
      for (int k = 0; k < elen * eno; k++) begin
        // occasional table rewrite in mid-block
        if ($urandom_range(0, 40) == 0)
          push_load($urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 63),
                    $urandom_range(0, 255), $urandom_range(0, 15));
        push_metric(rand_metric(), (k == 0) ? $urandom_range(0, 1)
                                            : ($urandom_range(0, 30) == 0));
      end
    close_block();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_operation = OP_LOAD;
    in_target_state = '0;
    in_slot = '0;
    in_prev_state = '0;
    in_input_symbol = '0;
    in_output_symbol = '0;
    in_metric = '0;
    in_packet_start = 1'b0;
    n_queued = 0;
    n_taken = 0;
    errors = 0;
    gaps_on = 1'b1;
    step_cnt = 0;
    sym_cnt = 0;
    bank = 1'b0;
    r_ns = 7'd4;
    r_no = 5'd4;
    r_len = 7'd64;
    r_start = 7'h7F;
    r_end = 7'h7F;
    for (int e = 0; e < 256; e++) tr_vld[e] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2 states, 2 symbols, 3 steps, known start and end.
    write_reg(REG_NUM_STATES, 7'd2);
    write_reg(REG_NUM_OUT_SYM, 7'd2);
    write_reg(REG_BLOCK_LEN, 7'd3);
    write_reg(REG_START_STATE, 7'd0);
    write_reg(REG_END_STATE, 7'd1);
    push_load(63, 3, 63, 255, 15);           // field extremes, unused state
    push_load(0, 0, 0, 8'h11, 0);
    push_load(0, 1, 1, 8'h22, 1);
    push_load(1, 0, 0, 8'h33, 1);
    push_load(1, 1, 1, 8'h44, 0);            // may tie with slot 0: first slot wins
    push_load(1, 2, 40, 8'h55, 0);           // predecessor out of range
    push_load(0, 2, 1, 8'h66, 9);            // output symbol out of range
    push_metric(65535, 1'b1);                // packet start on first beat: no effect
    push_metric(0, 1'b0);
    push_metric(7, 1'b0);
    push_metric(7, 1'b0);
    push_metric(65535, 1'b0);
    push_metric(1, 1'b1);                    // packet start in mid-block
    push_metric(3, 1'b0);
    push_metric(0, 1'b0);
    repeat (4) push_metric($urandom_range(0, 9), 1'b0);
    close_block();

    // Each phase waits out the drain at its end: sender pauses for all results.
    run_phase(0, 0, 0, 127, 127, 8, 1'b1);    // zero registers act as one
    run_phase(4, 2, 8, 1, 2, 2, 1'b1);
    run_phase(5, 1, 127, 127, 63, 1, 1'b0);   // saturated block, end out of range
    run_phase(8, 31, 2, 50, 127, 1, 1'b1);    // saturated symbols, start out of range
    run_phase(6, 3, 5, 64, 5, 1, 1'b1);       // negative start state

    wait_drained();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tvbd_pkg.sv
rtl/tvbd_acs_unit.sv
rtl/trellis_viterbi_block_decoder.sv
tb/sv/trellis_viterbi_block_decoder_test.sv
